// ===== rtl/core/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the pressure and temperature compensation.
// ----------------------------------------------------------------------------
package bpc_pkg;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_CAL_TEMPERATURE   = 2'd0,
      CSR_CAL_PRESSURE_LOW  = 2'd1,
      CSR_CAL_PRESSURE_HIGH = 2'd2,
      CSR_CAL_PRESSURE_NINE = 2'd3
   } csr_index_type;

   localparam int unsigned DIV_STAGES = 64;

   localparam logic signed [25:0] FINE_OFFSET = 26'sd128000;
   localparam logic [20:0]        PRES_OFFSET = 21'd1048576;
   localparam logic [11:0]        DIV_SCALE   = 12'd3125;
   localparam logic signed [27:0] TEMP_ROUND  = 28'sd128;
   localparam logic signed [63:0] P1_BIAS     = 64'sh0000_8000_0000_0000;
   localparam logic signed [19:0] TEMP_MAX    = 20'sd32767;
   localparam logic signed [19:0] TEMP_MIN    = -20'sd32768;
   localparam logic signed [63:0] PRES_MAX    = 64'sd4194303;

   // Decoded calibration words
   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } cal_type;

   // Per-item side data that rides along the divider
   typedef struct packed {
      logic               qneg;
      logic               pvalid;
      logic signed [15:0] temp;
   } side_type;

   typedef struct packed {
      logic [63:0] num_mag;
      logic [30:0] den_mag;
      side_type    side;
   } front_type;

   typedef struct packed {
      logic [63:0] quo;
      side_type    side;
   } quo_type;

endpackage

// ===== rtl/core/bpc_front.sv =====
// ----------------------------------------------------------------------------
// bpc_front
// Fine temperature, temperature result and pressure divisor / dividend.
// ----------------------------------------------------------------------------
module bpc_front
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [19:0] adc_p,
   input  logic [19:0] adc_t,
   input  cal_type     cal,
   output logic        out_valid,
   output front_type   out_item
);

   logic [11:1] v_ff;

   logic signed [17:0] tdiff;
   logic signed [16:0] dt;
   logic signed [33:0] s1_ta_ff, s1_ta_in, s1_dd_ff, s1_dd_in;
   logic        [20:0] s1_pr_ff, s1_pr_in;

   logic signed [22:0] s2_at_ff, s2_at_in;
   logic signed [21:0] dd_sh;
   logic signed [37:0] s2_bt_ff, s2_bt_in;
   logic        [20:0] s2_pr_ff;

   logic signed [24:0] s3_fine_ff, s3_fine_in;
   logic        [20:0] s3_pr_ff;

   logic signed [19:0] tr;
   logic signed [15:0] s4_temp_ff, s4_temp_in;
   logic signed [25:0] s4_pa_ff, s4_pa_in;
   logic        [20:0] s4_pr_ff;

   logic signed [51:0] s5_aa_ff, s5_aa_in;
   logic signed [41:0] s5_ap5_ff, s5_ap5_in, s5_ap2_ff, s5_ap2_in;
   logic signed [15:0] s5_temp_ff;
   logic        [20:0] s5_pr_ff;

   logic signed [67:0] prod6, prod3;
   logic signed [63:0] s6_b6_ff, s6_c3_ff;
   logic signed [41:0] s6_ap5_ff, s6_ap2_ff;
   logic signed [15:0] s6_temp_ff;
   logic        [20:0] s6_pr_ff;

   logic signed [63:0] s7_b_ff, s7_b_in, a2, s7_x_ff, s7_x_in;
   logic signed [15:0] s7_temp_ff;
   logic        [20:0] s7_pr_ff;

   logic        [47:0] s8_xl_ff, s8_xl_in;
   logic        [47:0] xh_full;
   logic        [31:0] s8_xh_ff;
   logic        [63:0] s8_n0_ff, s8_n0_in;
   logic signed [15:0] s8_temp_ff;

   logic        [63:0] prod1;
   logic signed [30:0] s9_a3_ff;
   logic        [43:0] s9_nl_ff, s9_nl_in, nh_full;
   logic        [31:0] s9_nh_ff;
   logic signed [15:0] s9_temp_ff;

   logic        [63:0] s10_num_ff, s10_num_in;
   logic signed [30:0] s10_a3_ff;
   logic signed [15:0] s10_temp_ff;

   front_type s11_ff, s11_in;

   // Stage 1: temperature differences and first products
   always_comb begin
      tdiff = $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
      dt    = $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, cal.t1});
      s1_ta_in = tdiff * cal.t2;
      s1_dd_in = dt * dt;
      s1_pr_in = PRES_OFFSET - {1'b0, adc_p};
   end

   // Stage 2: scale and cubic term product
   always_comb begin
      s2_at_in = 23'(s1_ta_ff >>> 11);
      dd_sh    = 22'(s1_dd_ff >>> 12);
      s2_bt_in = dd_sh * cal.t3;
   end

   // Stage 3: fine temperature
   assign s3_fine_in = 25'(s2_at_ff) + 25'(s2_bt_ff >>> 14);

   // Stage 4: temperature result and pressure offset
   always_comb begin
      tr = 20'((28'(s3_fine_ff) * 28'sd5 + TEMP_ROUND) >>> 8);
      if (tr > TEMP_MAX) begin
         s4_temp_in = 16'sh7fff;
      end else if (tr < TEMP_MIN) begin
         s4_temp_in = -16'sh8000;
      end else begin
         s4_temp_in = tr[15:0];
      end
      s4_pa_in = 26'(s3_fine_ff) - FINE_OFFSET;
   end

   // Stage 5: square and linear products
   always_comb begin
      s5_aa_in  = s4_pa_ff * s4_pa_ff;
      s5_ap5_in = s4_pa_ff * cal.p5;
      s5_ap2_in = s4_pa_ff * cal.p2;
   end

   // Stage 6: quadratic products, wrapped to 64 bits
   always_comb begin
      prod6 = s5_aa_ff * cal.p6;
      prod3 = s5_aa_ff * cal.p3;
   end

   // Stage 7: collect dividend offset and divisor polynomial
   always_comb begin
      s7_b_in = s6_b6_ff + (64'(s6_ap5_ff) <<< 17) + (64'(cal.p4) <<< 35);
      a2      = (s6_c3_ff >>> 8) + (64'(s6_ap2_ff) <<< 12);
      s7_x_in = a2 + P1_BIAS;
   end

   // Stage 8: divisor times P1 as partial products, raw dividend
   always_comb begin
      s8_xl_in = s7_x_ff[31:0] * cal.p1;
      xh_full  = s7_x_ff[63:32] * cal.p1;
      s8_n0_in = ({43'd0, s7_pr_ff} << 31) - s7_b_ff;
   end

   // Stage 9: divisor sum, dividend scale partial products
   always_comb begin
      prod1    = {16'd0, s8_xl_ff} + {s8_xh_ff, 32'd0};
      s9_nl_in = s8_n0_ff[31:0] * DIV_SCALE;
      nh_full  = s8_n0_ff[63:32] * DIV_SCALE;
   end

   // Stage 10: dividend sum
   assign s10_num_in = {20'd0, s9_nl_ff} + {s9_nh_ff, 32'd0};

   // Stage 11: magnitudes and signs for the divider
   always_comb begin
      s11_in.num_mag     = s10_num_ff[63] ? (64'd0 - s10_num_ff) : s10_num_ff;
      s11_in.den_mag     = s10_a3_ff[30] ? 31'(-s10_a3_ff) : 31'(s10_a3_ff);
      s11_in.side.qneg   = s10_num_ff[63] ^ s10_a3_ff[30];
      s11_in.side.pvalid = (s10_a3_ff != 31'sd0);
      s11_in.side.temp   = s10_temp_ff;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[10:1], in_valid};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ta_ff    <= s1_ta_in;
         s1_dd_ff    <= s1_dd_in;
         s1_pr_ff    <= s1_pr_in;
         s2_at_ff    <= s2_at_in;
         s2_bt_ff    <= s2_bt_in;
         s2_pr_ff    <= s1_pr_ff;
         s3_fine_ff  <= s3_fine_in;
         s3_pr_ff    <= s2_pr_ff;
         s4_temp_ff  <= s4_temp_in;
         s4_pa_ff    <= s4_pa_in;
         s4_pr_ff    <= s3_pr_ff;
         s5_aa_ff    <= s5_aa_in;
         s5_ap5_ff   <= s5_ap5_in;
         s5_ap2_ff   <= s5_ap2_in;
         s5_temp_ff  <= s4_temp_ff;
         s5_pr_ff    <= s4_pr_ff;
         s6_b6_ff    <= prod6[63:0];
         s6_c3_ff    <= prod3[63:0];
         s6_ap5_ff   <= s5_ap5_ff;
         s6_ap2_ff   <= s5_ap2_ff;
         s6_temp_ff  <= s5_temp_ff;
         s6_pr_ff    <= s5_pr_ff;
         s7_b_ff     <= s7_b_in;
         s7_x_ff     <= s7_x_in;
         s7_temp_ff  <= s6_temp_ff;
         s7_pr_ff    <= s6_pr_ff;
         s8_xl_ff    <= s8_xl_in;
         s8_xh_ff    <= xh_full[31:0];
         s8_n0_ff    <= s8_n0_in;
         s8_temp_ff  <= s7_temp_ff;
         s9_a3_ff    <= $signed(prod1[63:33]);
         s9_nl_ff    <= s9_nl_in;
         s9_nh_ff    <= nh_full[31:0];
         s9_temp_ff  <= s8_temp_ff;
         s10_num_ff  <= s10_num_in;
         s10_a3_ff   <= s9_a3_ff;
         s10_temp_ff <= s9_temp_ff;
         s11_ff      <= s11_in;
      end
   end

   assign out_valid = v_ff[11];
   assign out_item  = s11_ff;

endmodule

// ===== rtl/core/bpc_div.sv =====
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_div
   import bpc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  front_type in_item,
   output logic      out_valid,
   output quo_type   out_item
);

   logic [DIV_STAGES-1:0] v_ff;
   logic [30:0]           rem_ff [DIV_STAGES];
   logic [63:0]           quo_ff [DIV_STAGES];
   logic [30:0]           den_ff [DIV_STAGES];
   side_type              side_ff [DIV_STAGES];

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   genvar k;
   for (k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [30:0] rem_prev;
      logic [63:0] quo_prev;
      logic [30:0] den_prev;
      side_type    side_prev;
      logic [31:0] trial;
      logic [32:0] diff;
      logic        take;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign quo_prev  = in_item.num_mag;
         assign den_prev  = in_item.den_mag;
         assign side_prev = in_item.side;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // Shift in the next dividend bit and try the subtract
      assign trial = {rem_prev, quo_prev[63]};
      assign diff  = {1'b0, trial} - {2'b00, den_prev};
      assign take  = !diff[32];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? diff[30:0] : trial[30:0];
            quo_ff[k]  <= {quo_prev[62:0], take};
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid     = v_ff[DIV_STAGES-1];
   assign out_item.quo  = quo_ff[DIV_STAGES-1];
   assign out_item.side = side_ff[DIV_STAGES-1];

endmodule

// ===== rtl/core/bpc_post.sv =====
// ----------------------------------------------------------------------------
// bpc_post
// Quadratic pressure correction, saturation and the output register.
// ----------------------------------------------------------------------------
module bpc_post
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  quo_type     in_item,
   input  cal_type     cal,
   output logic        out_valid,
   output logic [15:0] out_temp,
   output logic [21:0] out_pres,
   output logic        out_pvalid
);

   logic [7:1] v_ff;
   side_type   sd_ff [6];

   logic signed [63:0] s1_p_ff, s1_p_in;

   logic signed [63:0] d;
   logic        [63:0] s2_ll_ff;
   logic        [63:0] cross_full;
   logic        [31:0] s2_cr_ff;
   logic signed [48:0] s2_pl8_ff, s2_pl8_in;
   logic signed [47:0] ph8_full;
   logic        [31:0] s2_ph8_ff;
   logic signed [63:0] s2_p_ff;

   logic        [63:0] s3_dd_ff;
   logic signed [63:0] b64, s3_b_ff, s3_p_ff;

   logic signed [48:0] s4_dl9_ff, s4_dl9_in;
   logic signed [47:0] dh9_full;
   logic        [31:0] s4_dh9_ff;
   logic signed [63:0] s4_b_ff, s4_p_ff;

   logic signed [63:0] a64, s5_a_ff, s5_b_ff, s5_p_ff;

   logic signed [63:0] sum3, s6_pp_ff, s6_pp_in;

   logic signed [63:0] ps;
   logic        [21:0] pres_in;
   logic [15:0] temp_ff;
   logic [21:0] pres_ff;
   logic        pvalid_ff;

   // Stage 1: apply the quotient sign
   assign s1_p_in = $signed(in_item.side.qneg ? (64'd0 - in_item.quo) : in_item.quo);

   // Stage 2: partial products of d squared and p times P8
   always_comb begin
      d          = s1_p_ff >>> 13;
      cross_full = d[31:0] * d[63:32];
      s2_pl8_in  = $signed({1'b0, s1_p_ff[31:0]}) * cal.p8;
      ph8_full   = $signed(s1_p_ff[63:32]) * cal.p8;
   end

   // Stage 3: sum partial products
   always_comb begin
      b64 = 64'(s2_pl8_ff) + $signed({s2_ph8_ff, 32'd0});
   end

   // Stage 4: d squared times P9 as partial products
   always_comb begin
      s4_dl9_in = $signed({1'b0, s3_dd_ff[31:0]}) * cal.p9;
      dh9_full  = $signed(s3_dd_ff[63:32]) * cal.p9;
   end

   // Stage 5: sum the P9 term
   assign a64 = 64'(s4_dl9_ff) + $signed({s4_dh9_ff, 32'd0});

   // Stage 6: combine terms and add the P7 offset
   always_comb begin
      sum3     = s5_p_ff + s5_a_ff + s5_b_ff;
      s6_pp_in = (sum3 >>> 8) + (64'(cal.p7) <<< 4);
   end

   // Stage 7: integer pascals, saturate, drop when divisor was zero
   always_comb begin
      ps = s6_pp_ff >>> 8;
      if (!sd_ff[5].pvalid || ps < 64'sd0) begin
         pres_in = '0;
      end else if (ps > PRES_MAX) begin
         pres_in = PRES_MAX[21:0];
      end else begin
         pres_in = ps[21:0];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[6:1], in_valid};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0]  <= in_item.side;
         for (int i = 1; i < 6; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
         s1_p_ff   <= s1_p_in;
         s2_ll_ff  <= d[31:0] * d[31:0];
         s2_cr_ff  <= cross_full[31:0];
         s2_pl8_ff <= s2_pl8_in;
         s2_ph8_ff <= ph8_full[31:0];
         s2_p_ff   <= s1_p_ff;
         s3_dd_ff  <= s2_ll_ff + {s2_cr_ff[30:0], 33'd0};
         s3_b_ff   <= b64 >>> 19;
         s3_p_ff   <= s2_p_ff;
         s4_dl9_ff <= s4_dl9_in;
         s4_dh9_ff <= dh9_full[31:0];
         s4_b_ff   <= s3_b_ff;
         s4_p_ff   <= s3_p_ff;
         s5_a_ff   <= a64 >>> 25;
         s5_b_ff   <= s4_b_ff;
         s5_p_ff   <= s4_p_ff;
         s6_pp_ff  <= s6_pp_in;
         temp_ff   <= sd_ff[5].temp;
         pres_ff   <= pres_in;
         pvalid_ff <= sd_ff[5].pvalid;
      end
   end

   assign out_valid  = v_ff[7];
   assign out_temp   = temp_ff;
   assign out_pres   = pres_ff;
   assign out_pvalid = pvalid_ff;

endmodule

// ===== rtl/core/baro_pressure_temp_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit
// Integer pressure and temperature compensation of raw barometer readings.
// ----------------------------------------------------------------------------
// Usage:
//   Load the calibration words through the csr_ port while no item is in
//   flight: index 0 temperature words, 1 P1..P4, 2 P5..P8, 3 P9.
//   Feed one pair of raw 20-bit readings per item on the req_ stream; each
//   item yields exactly one result item on the rsp_ stream, in order.
//   From acceptance to rsp_tvalid an item passes 11 front stages, 64
//   divider stages (one quotient bit each) and 7 correction stages; the
//   divider sets the depth. One item per clock unless rsp_tready stalls.
//   When rsp_tready is low while a result waits, the whole pipeline holds
//   and req_tready drops; nothing is lost or repeated. Bubbles do not fill.
//   Reset clears all valid bits and the calibration registers to zero.
//   A zero divisor gives pressure 0 and pressure_valid low on rsp_tuser.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_unit
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // adc_pressure [19:0], adc_temperature [39:20]
   input  logic [39:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // temperature_centi [15:0], pressure_pa [37:16], zero [39:38]
   output logic [39:0] rsp_tdata,
   // pressure_valid [0]
   output logic        rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [47:0] cal_t_ff;
   logic [63:0] cal_pl_ff, cal_ph_ff;
   logic [15:0] cal_p9_ff;
   cal_type     cal;
   logic        en;
   logic        front_valid, div_valid;
   front_type   front_item;
   quo_type     div_item;
   logic [15:0] temp;
   logic [21:0] pres;

   // Write calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t_ff  <= '0;
         cal_pl_ff <= '0;
         cal_ph_ff <= '0;
         cal_p9_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CAL_TEMPERATURE:   cal_t_ff  <= csr_wdata[47:0];
            CSR_CAL_PRESSURE_LOW:  cal_pl_ff <= csr_wdata;
            CSR_CAL_PRESSURE_HIGH: cal_ph_ff <= csr_wdata;
            CSR_CAL_PRESSURE_NINE: cal_p9_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Unpack calibration words
   always_comb begin
      cal.t1 = cal_t_ff[15:0];
      cal.t2 = $signed(cal_t_ff[31:16]);
      cal.t3 = $signed(cal_t_ff[47:32]);
      cal.p1 = cal_pl_ff[15:0];
      cal.p2 = $signed(cal_pl_ff[31:16]);
      cal.p3 = $signed(cal_pl_ff[47:32]);
      cal.p4 = $signed(cal_pl_ff[63:48]);
      cal.p5 = $signed(cal_ph_ff[15:0]);
      cal.p6 = $signed(cal_ph_ff[31:16]);
      cal.p7 = $signed(cal_ph_ff[47:32]);
      cal.p8 = $signed(cal_ph_ff[63:48]);
      cal.p9 = $signed(cal_p9_ff);
   end

   // Hold every stage while a result waits
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   bpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .adc_p     (req_tdata[19:0]),
      .adc_t     (req_tdata[39:20]),
      .cal       (cal),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   bpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .out_valid (div_valid),
      .out_item  (div_item)
   );

   bpc_post u_post (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (div_valid),
      .in_item    (div_item),
      .cal        (cal),
      .out_valid  (rsp_tvalid),
      .out_temp   (temp),
      .out_pres   (pres),
      .out_pvalid (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, pres, temp};

endmodule
